[src/sndr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the sigmoid knot table for the sigmoid neuron trainer.
// No dependencies; the core, sndr_cfg and sndr_row_ops refer to it by scoped names.
package sndr_pkg;

	// Field and arithmetic widths
	localparam int WEIGHT_W   = 24;
	localparam int PIXEL_BITS = 25;
	localparam int NEURON_W   = 5;
	localparam int Q16_W      = 16;
	localparam int STEP_W     = 17;
	localparam int GROUP_SIZE = 8;
	localparam int SIG_LIMIT  = 524288;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_TOLERANCE  = 1'b0;
	localparam logic REG_LEARN_RATE = 1'b1;
	localparam logic [Q16_W-1:0] TOLERANCE_RST  = 16'd9830;
	localparam logic [Q16_W-1:0] LEARN_RATE_RST = 16'd32768;

	// Operation codes
	localparam logic OP_EVAL  = 1'b0;
	localparam logic OP_TRAIN = 1'b1;

	typedef struct packed {
		logic                  operation;
		logic [NEURON_W-1:0]   neuron;
		logic [PIXEL_BITS-1:0] pixels;
		logic                  desired;
	} item_t;

	typedef struct packed {
		logic [Q16_W-1:0] output_level;
		logic             within_tolerance;
	} result_t;

	typedef struct packed {
		logic [Q16_W-1:0] tolerance;
		logic [Q16_W-1:0] learn_rate;
	} cfg_t;

	// Sequencer controls toward the row unit
	typedef struct packed {
		logic grp_load;
		logic sum_load;
		logic row_used;
	} row_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_TOTAL,
		ST_SIGM,
		ST_CHECK,
		ST_DELTA,
		ST_SCALE,
		ST_UPDATE
	} state_t;

	// Sigmoid knots: round(65536 * sig(k/2)) for k = 0..16
	function automatic logic [Q16_W-1:0] sig_point(input logic [4:0] k);
		logic [Q16_W-1:0] v;
		unique case (k)
			5'd0:    v = 16'd32768;
			5'd1:    v = 16'd40793;
			5'd2:    v = 16'd47911;
			5'd3:    v = 16'd53581;
			5'd4:    v = 16'd57724;
			5'd5:    v = 16'd60565;
			5'd6:    v = 16'd62428;
			5'd7:    v = 16'd63615;
			5'd8:    v = 16'd64357;
			5'd9:    v = 16'd64816;
			5'd10:   v = 16'd65097;
			5'd11:   v = 16'd65269;
			5'd12:   v = 16'd65374;
			5'd13:   v = 16'd65438;
			5'd14:   v = 16'd65476;
			5'd15:   v = 16'd65500;
			default: v = 16'd65514;
		endcase
		return v;
	endfunction

endpackage

[src/sigmoid_neuron_delta_rule_trainer_core.sv]
`timescale 1ns / 1ps
// Top level of the sigmoid neuron trainer: sequencer, scalar arithmetic, weight RAM.
// Depends on sndr_pkg, sndr_ram, sndr_cfg and sndr_row_ops.
//
// Usage:
//   Input: drive item and raise start; the item transfers at a clock edge where start is
//   high and busy is low. Each item evaluates one neuron's weight row against a 25-pixel
//   image and, with the train operation and an error outside tolerance, updates that row.
//   Output: exactly one result per item, shown on result for a single cycle with done
//   high. The receiver cannot stall; done is a one-cycle strobe.
//   Sequence: an item passes FETCH, TOTAL, SIGM and CHECK; done is registered from CHECK.
//   A training item that needs an update then also passes DELTA, SCALE and UPDATE.
//   Busy: busy stays high from the input transfer until the sequencer is back in idle,
//   so a new item is taken only once the last one is through, its write-back included.
//   The work is the read, two-level sum, sigmoid, error, two multiply stages and
//   write-back of one weight-RAM row; the RAM holds one neuron per word, so a row is
//   read, modified and written whole.
//   Configuration: tolerance at byte address 0, learn_rate at 4 (Q0.16); write only while
//   busy is low and no result is pending.
//   Reset: clears the sequencer and the per-row valid bits, so every weight reads as zero
//   at once; no clearing pass runs. Registers return to 0.15 and 0.5.
module sigmoid_neuron_delta_rule_trainer_core #(
	parameter int NEURONS = 32,
	parameter int INPUTS  = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  sndr_pkg::item_t               item,
	output logic                          done,
	output sndr_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sndr_pkg::ADDR_W-1:0]   paddr,
	input  logic [sndr_pkg::DATA_W-1:0]   pwdata,
	output logic [sndr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int W     = sndr_pkg::WEIGHT_W;
	localparam int ROW_W = INPUTS * W;
	localparam int AW    = NEURONS > 1 ? $clog2(NEURONS) : 1;
	localparam int SUM_W = W + $clog2(INPUTS + 1);
	localparam int QW    = sndr_pkg::Q16_W;

	sndr_pkg::state_t   state_q;
	sndr_pkg::state_t   state_d;
	sndr_pkg::cfg_t     cfg;
	sndr_pkg::row_ctl_t row_ctl;
	sndr_pkg::item_t    item_q;
	sndr_pkg::result_t  result_q;

	logic [31:0]        neuron_ext;
	logic               in_bank;
	logic               in_bank_q;
	logic [AW-1:0]      addr_q;
	logic [NEURONS-1:0] row_vld_q;
	logic               done_q;

	logic               mem_en;
	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic [ROW_W-1:0]   mem_rdata;
	logic [ROW_W-1:0]   mem_wdata;
	logic [INPUTS-1:0]  pix_en;

	logic signed [SUM_W-1:0] sum_s2;
	logic                    sum_neg;
	logic [SUM_W-1:0]        sum_mag;
	logic                    sum_clamp;
	logic [4:0]              knot;
	logic [QW-1:0]           knot_lo;
	logic [QW-1:0]           knot_hi;
	logic [QW-1:0]           knot_diff;
	logic [30:0]             interp;
	logic [QW:0]             y_pos;
	logic [QW-1:0]           y_c;
	logic [QW-1:0]           y_s3;

	logic [QW:0]             y_comp;
	logic [QW:0]             err_mag;
	logic                    ok_c;
	logic [2*QW:0]           p_full;
	logic [14:0]             p_s4;
	logic [QW:0]             mag_s4;
	logic                    neg_s4;
	logic [31:0]             dm_s5;
	logic [47:0]             scaled;
	logic [47:0]             scaled_rnd;
	logic [QW-1:0]           step_mag;
	logic signed [sndr_pkg::STEP_W-1:0] step_s6;

	// Configuration registers
	sndr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Weight store: one neuron row per word
	sndr_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NEURONS)
	) u_wram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	sndr_row_ops #(
		.INPUTS (INPUTS)
	) u_row (
		.clk    (clk),
		.ctl    (row_ctl),
		.rdata  (mem_rdata),
		.pix_en (pix_en),
		.step   (step_s6),
		.sum    (sum_s2),
		.wdata  (mem_wdata)
	);

	// Decode the neuron index of the incoming item
	assign neuron_ext = {{(32 - sndr_pkg::NEURON_W){1'b0}}, item.neuron};
	assign in_bank    = neuron_ext < 32'(NEURONS);
	assign mem_addr   = (state_q == sndr_pkg::ST_IDLE) ? neuron_ext[AW-1:0] : addr_q;

	// Lanes beyond the pixel field see zero
	for (genvar t = 0; t < INPUTS; t++) begin : g_pix
		if (t < sndr_pkg::PIXEL_BITS) begin : g_on
			assign pix_en[t] = item_q.pixels[t];
		end else begin : g_off
			assign pix_en[t] = 1'b0;
		end
	end

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sndr_pkg::ST_IDLE:   if (start) state_d = sndr_pkg::ST_FETCH;
			sndr_pkg::ST_FETCH:  state_d = sndr_pkg::ST_TOTAL;
			sndr_pkg::ST_TOTAL:  state_d = sndr_pkg::ST_SIGM;
			sndr_pkg::ST_SIGM:   state_d = sndr_pkg::ST_CHECK;
			sndr_pkg::ST_CHECK: begin
				if (item_q.operation == sndr_pkg::OP_TRAIN && !ok_c && in_bank_q) begin
					state_d = sndr_pkg::ST_DELTA;
				end else begin
					state_d = sndr_pkg::ST_IDLE;
				end
			end
			sndr_pkg::ST_DELTA:  state_d = sndr_pkg::ST_SCALE;
			sndr_pkg::ST_SCALE:  state_d = sndr_pkg::ST_UPDATE;
			sndr_pkg::ST_UPDATE: state_d = sndr_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		mem_en           = 1'b0;
		mem_we           = 1'b0;
		row_ctl.grp_load = 1'b0;
		row_ctl.sum_load = 1'b0;
		row_ctl.row_used = in_bank_q && row_vld_q[addr_q];
		unique case (state_q)
			sndr_pkg::ST_IDLE:   mem_en = start && in_bank;
			sndr_pkg::ST_FETCH:  row_ctl.grp_load = 1'b1;
			sndr_pkg::ST_TOTAL:  row_ctl.sum_load = 1'b1;
			sndr_pkg::ST_SCALE:  mem_en = 1'b1;
			sndr_pkg::ST_UPDATE: begin
				mem_en = 1'b1;
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != sndr_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sndr_pkg::ST_IDLE;
			row_vld_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == sndr_pkg::ST_CHECK);
			if (state_q == sndr_pkg::ST_UPDATE) begin
				row_vld_q[addr_q] <= 1'b1;
			end
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (state_q == sndr_pkg::ST_IDLE && start) begin
			item_q    <= item;
			in_bank_q <= in_bank;
			addr_q    <= neuron_ext[AW-1:0];
		end
	end

	// Sigmoid: clamp |sum| to 8.0 and interpolate between knots
	assign sum_neg   = sum_s2[SUM_W-1];
	assign sum_mag   = sum_neg ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);
	assign sum_clamp = sum_mag >= SUM_W'(sndr_pkg::SIG_LIMIT);
	assign knot      = {1'b0, sum_mag[18:15]};
	assign knot_lo   = sndr_pkg::sig_point(knot);
	assign knot_hi   = sndr_pkg::sig_point(knot + 5'd1);
	assign knot_diff = knot_hi - knot_lo;
	assign interp    = 31'(knot_diff) * 31'(sum_mag[14:0]);
	assign y_pos     = sum_clamp ? (QW+1)'(sndr_pkg::sig_point(5'd16))
	                             : (QW+1)'(knot_lo) + (QW+1)'(interp[30:15]);
	assign y_c       = sum_neg ? QW'(17'h10000 - y_pos) : y_pos[QW-1:0];

	// Error against the wanted response, and y*(1-y)
	assign y_comp  = 17'h10000 - {1'b0, y_s3};
	assign err_mag = item_q.desired ? y_comp : {1'b0, y_s3};
	assign ok_c    = err_mag <= {1'b0, cfg.tolerance};
	assign p_full  = (2*QW+1)'(y_s3) * (2*QW+1)'(y_comp);

	// Step magnitude: round half away from zero on |d| * learn_rate / 2^32
	assign scaled     = 48'(dm_s5) * 48'(cfg.learn_rate);
	assign scaled_rnd = scaled + 48'h0000_8000_0000;
	assign step_mag   = scaled_rnd[47:32];

	always_ff @(posedge clk) begin
		if (state_q == sndr_pkg::ST_SIGM) begin
			y_s3 <= y_c;
		end
		if (state_q == sndr_pkg::ST_CHECK) begin
			p_s4                      <= p_full[30:16];
			mag_s4                    <= err_mag;
			neg_s4                    <= !item_q.desired;
			result_q.output_level     <= y_s3;
			result_q.within_tolerance <= ok_c;
		end
		if (state_q == sndr_pkg::ST_DELTA) begin
			dm_s5 <= 32'(p_s4) * 32'(mag_s4);
		end
		if (state_q == sndr_pkg::ST_SCALE) begin
			step_s6 <= neg_s4 ? -sndr_pkg::STEP_W'(step_mag) : sndr_pkg::STEP_W'(step_mag);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[src/sndr_ram.sv]
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module sndr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read one word per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[src/sndr_cfg.sv]
`timescale 1ns / 1ps
// APB-style configuration registers: tolerance and learning rate.
// Depends on sndr_pkg.
module sndr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sndr_pkg::ADDR_W-1:0]   paddr,
	input  logic [sndr_pkg::DATA_W-1:0]   pwdata,
	output logic [sndr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output sndr_pkg::cfg_t                cfg
);

	logic reg_sel;
	logic wr_xfer;
	logic [sndr_pkg::Q16_W-1:0] tolerance_q;
	logic [sndr_pkg::Q16_W-1:0] learn_rate_q;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_xfer = psel && penable && pwrite && pready;

	// Update the addressed register on a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q  <= sndr_pkg::TOLERANCE_RST;
			learn_rate_q <= sndr_pkg::LEARN_RATE_RST;
		end else if (wr_xfer) begin
			unique case (reg_sel)
				sndr_pkg::REG_TOLERANCE:  tolerance_q  <= pwdata[sndr_pkg::Q16_W-1:0];
				sndr_pkg::REG_LEARN_RATE: learn_rate_q <= pwdata[sndr_pkg::Q16_W-1:0];
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		unique case (reg_sel)
			sndr_pkg::REG_TOLERANCE:  prdata = sndr_pkg::DATA_W'(tolerance_q);
			sndr_pkg::REG_LEARN_RATE: prdata = sndr_pkg::DATA_W'(learn_rate_q);
		endcase
	end

	assign cfg.tolerance  = tolerance_q;
	assign cfg.learn_rate = learn_rate_q;

endmodule

[src/sndr_row_ops.sv]
`timescale 1ns / 1ps
// Row unit: masked weighted sum over two registered adder levels, and the
// saturating delta-rule update of a whole weight row. Depends on sndr_pkg.
module sndr_row_ops #(
	parameter int INPUTS = 25
) (
	input  logic                                       clk,
	input  sndr_pkg::row_ctl_t                         ctl,
	input  logic [INPUTS*sndr_pkg::WEIGHT_W-1:0]       rdata,
	input  logic [INPUTS-1:0]                          pix_en,
	input  logic signed [sndr_pkg::STEP_W-1:0]         step,
	output logic signed [sndr_pkg::WEIGHT_W+$clog2(INPUTS+1)-1:0] sum,
	output logic [INPUTS*sndr_pkg::WEIGHT_W-1:0]       wdata
);

	localparam int W      = sndr_pkg::WEIGHT_W;
	localparam int GS     = sndr_pkg::GROUP_SIZE;
	localparam int GROUPS = (INPUTS + GS - 1) / GS;
	localparam int GRP_W  = W + $clog2(GS + 1);
	localparam int SUM_W  = W + $clog2(INPUTS + 1);

	logic signed [W-1:0]     wm [GROUPS*GS];
	logic signed [GRP_W-1:0] grp_c [GROUPS];
	logic signed [GRP_W-1:0] grp_s1 [GROUPS];
	logic signed [SUM_W-1:0] tot_c;
	logic signed [SUM_W-1:0] sum_s2;

	// Mask each weight by its pixel and the row's valid state
	for (genvar t = 0; t < GROUPS*GS; t++) begin : g_mask
		if (t < INPUTS) begin : g_live
			assign wm[t] = (ctl.row_used && pix_en[t]) ? rdata[t*W +: W] : '0;
		end else begin : g_pad
			assign wm[t] = '0;
		end
	end

	// First level: one sum per group of lanes
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_c[g] = '0;
			for (int k = 0; k < GS; k++) begin
				grp_c[g] = grp_c[g] + GRP_W'(wm[g*GS + k]);
			end
		end
	end

	// Second level: sum the group results
	always_comb begin
		tot_c = '0;
		for (int g = 0; g < GROUPS; g++) begin
			tot_c = tot_c + SUM_W'(grp_s1[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.grp_load) begin
			grp_s1 <= grp_c;
		end
		if (ctl.sum_load) begin
			sum_s2 <= tot_c;
		end
	end

	assign sum = sum_s2;

	// Add the step to every lit weight, saturating at the weight range
	for (genvar t = 0; t < INPUTS; t++) begin : g_upd
		logic signed [W-1:0] old_w;
		logic signed [W:0]   new_w;
		assign old_w = ctl.row_used ? rdata[t*W +: W] : '0;
		assign new_w = (W+1)'(old_w) + (W+1)'(step);
		always_comb begin
			if (!pix_en[t]) begin
				wdata[t*W +: W] = old_w;
			end else if (new_w[W] != new_w[W-1]) begin
				wdata[t*W +: W] = new_w[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				wdata[t*W +: W] = new_w[W-1:0];
			end
		end
	end

endmodule

[src/sndr_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the trainer's command handshake and result strobe.
// Depends on sigmoid_neuron_delta_rule_trainer_core, which it binds to.
module sndr_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// An accepted item keeps the block busy through its work, from fetch to check
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 busy ##1 busy ##1 busy)
		else $error("busy dropped before the result was formed");

	// Every transfer in yields a result strobe after the fetch, total, sigmoid and check states
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("result strobe missing after input transfer");

	// The result strobe lasts a single cycle
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// No result in the cycle right after an input transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe right after input transfer");

endmodule

bind sigmoid_neuron_delta_rule_trainer_core sndr_checker u_sndr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
